@@ hdl/lps_pkg.sv @@
// lps_pkg: shared constants, state encoding and divider status type for the
// linear prime sieve unit. No dependencies; compiled before every other file.
package lps_pkg;

   // field widths of the response payload and the internal datapath
   localparam int DATA_W  = 16;
   localparam int CAND_W  = 17;
   localparam int FOUND_W = 14;
   localparam int PROD_W  = 2 * DATA_W;

   // parameter defaults
   localparam int VALUE_RANGE_DEF = 65536;
   localparam int LIST_DEPTH_DEF  = 8192;

   // reset values
   localparam logic [DATA_W-1:0] LIMIT_RESET = 16'hFFFF;
   localparam logic [CAND_W-1:0] CAND_START  = 17'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MARK_CHK,
      ST_WALK_RD,
      ST_WALK_MUL,
      ST_WALK_CHK,
      ST_WALK_DIV,
      ST_FINISH
   } state_type;

   // status from the remainder unit back to the sequencer
   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_status_type;

endpackage

@@ hdl/lps_req_if.sv @@
// lps_req_if: request channel of the linear prime sieve unit.
// Depends on nothing; valid/ready handshake with a one-bit restart payload.
interface lps_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

@@ hdl/lps_rsp_if.sv @@
// lps_rsp_if: response channel of the linear prime sieve unit.
// Depends on lps_pkg for the payload widths.
interface lps_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lps_pkg::DATA_W-1:0]       candidate_value;
   logic                             is_prime;
   logic [lps_pkg::FOUND_W-1:0]      primes_found;
   logic                             done_res;

   modport source (output valid, output candidate_value, output is_prime,
                   output primes_found, output done_res, input ready);
   modport sink (input valid, input candidate_value, input is_prime,
                 input primes_found, input done_res, output ready);
endinterface

@@ hdl/linear_prime_sieve_unit.sv @@
// linear_prime_sieve_unit: linear (Euler) prime sieve, one candidate per request.
// Depends on lps_pkg, lps_req_if, lps_rsp_if and lps_rem_unit.
//
// Usage: each request on req_chan carries restart. restart=0 examines the
// next candidate (2, 3, 4, ...) and returns one response on rsp_chan with
// the candidate, its primality, the prime count and a done flag once the
// candidate passes csr_write_data's limit or the mark range. restart=1
// clears the sieve and returns an all-zero response. csr_write_en loads the
// limit; the user must load it only while idle, the block does not enforce it.
// Walk: an advance checks the candidate's mark, then walks the listed primes;
// each walk step is a list read, a multiply, a compare and a bit-serial
// remainder check. The walk stops at the smallest prime factor or once the
// product passes the limit, so most advances walk only a few primes.
// Reset: the mark memory is swept clear, one entry per cycle, over all
// VALUE_RANGE entries; a restart sweeps entries up to the highest one marked
// since the last sweep. No request is taken during a sweep.
// Stalls: the response sits in an output register; the next request is
// taken while it waits, and its own response is held until rsp_chan drains.
module linear_prime_sieve_unit #(
   parameter int VALUE_RANGE = lps_pkg::VALUE_RANGE_DEF,
   parameter int LIST_DEPTH  = lps_pkg::LIST_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   lps_req_if.sink                    req_chan,
   lps_rsp_if.source                  rsp_chan,
   input  logic                       csr_write_en,
   input  logic [lps_pkg::DATA_W-1:0] csr_write_data
);

   localparam int DATA_W  = lps_pkg::DATA_W;
   localparam int CAND_W  = lps_pkg::CAND_W;
   localparam int FOUND_W = lps_pkg::FOUND_W;
   localparam int PROD_W  = lps_pkg::PROD_W;
   localparam int ADDR_W  = $clog2(VALUE_RANGE);
   localparam int LIST_W  = $clog2(LIST_DEPTH);
   localparam int CNT_W   = $clog2(LIST_DEPTH + 1);

   lps_pkg::state_type state_ff, state_in;

   logic [DATA_W-1:0]  limit_ff;
   logic [CAND_W-1:0]  next_cand_ff, next_cand_in;
   logic [DATA_W-1:0]  cand_ff, cand_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [DATA_W-1:0]  p_ff, p_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [ADDR_W-1:0]  hi_ff, hi_in;
   logic               clr_pending_ff, clr_pending_in;
   logic               prime_ff, prime_in;

   logic [DATA_W-1:0]  res_cand_ff, res_cand_in;
   logic               res_prime_ff, res_prime_in;
   logic [FOUND_W-1:0] res_found_ff, res_found_in;
   logic               res_done_ff, res_done_in;

   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_cand_ff;
   logic               rsp_prime_ff;
   logic [FOUND_W-1:0] rsp_found_ff;
   logic               rsp_done_ff;

   logic               mark_mem [VALUE_RANGE];
   logic               mark_rd_ff;
   logic               mark_we;
   logic [ADDR_W-1:0]  mark_waddr;
   logic               mark_wdata;
   logic [ADDR_W-1:0]  mark_raddr;

   logic [DATA_W-1:0]  list_mem [LIST_DEPTH];
   logic [DATA_W-1:0]  list_rd_ff;
   logic               list_we;

   logic               req_ready;
   logic               rsp_load;
   logic               walk_end;
   logic               past_limit;
   logic               div_start;
   lps_pkg::div_status_type div_stat;

   // candidate beyond the limit or the mark range
   assign past_limit = (next_cand_ff > {1'b0, limit_ff}) ||
                       (PROD_W'(next_cand_ff) >= PROD_W'(VALUE_RANGE));

   // mark read is issued every cycle from the pending candidate, used after idle
   assign mark_raddr = ADDR_W'(next_cand_ff);

   // remainder check of the candidate by the current listed prime
   lps_rem_unit #(
      .DATA_W (DATA_W)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cand_ff),
      .divisor  (p_ff),
      .status   (div_stat)
   );

   // sequencer: next state and datapath updates
   always_comb begin
      state_in       = state_ff;
      next_cand_in   = next_cand_ff;
      cand_in        = cand_ff;
      cnt_in         = cnt_ff;
      j_in           = j_ff;
      p_in           = p_ff;
      prod_in        = prod_ff;
      clr_in         = clr_ff;
      hi_in          = hi_ff;
      clr_pending_in = clr_pending_ff;
      prime_in       = prime_ff;
      res_cand_in    = res_cand_ff;
      res_prime_in   = res_prime_ff;
      res_found_in   = res_found_ff;
      res_done_in    = res_done_ff;
      mark_we        = 1'b0;
      mark_waddr     = clr_ff;
      mark_wdata     = 1'b0;
      list_we        = 1'b0;
      div_start      = 1'b0;
      req_ready      = 1'b0;
      rsp_load       = 1'b0;
      walk_end       = 1'b0;

      case (state_ff)
         lps_pkg::ST_CLEAR: begin
            mark_we = 1'b1;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == hi_ff) begin
               clr_in   = '0;
               hi_in    = '0;
               state_in = lps_pkg::ST_IDLE;
            end
         end
         lps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.restart) begin
                  res_cand_in    = '0;
                  res_prime_in   = 1'b0;
                  res_found_in   = '0;
                  res_done_in    = 1'b0;
                  cnt_in         = '0;
                  next_cand_in   = lps_pkg::CAND_START;
                  clr_pending_in = 1'b1;
                  state_in       = lps_pkg::ST_FINISH;
               end else if (past_limit) begin
                  res_cand_in  = '0;
                  res_prime_in = 1'b0;
                  res_found_in = FOUND_W'(cnt_ff);
                  res_done_in  = 1'b1;
                  state_in     = lps_pkg::ST_FINISH;
               end else begin
                  cand_in  = DATA_W'(next_cand_ff);
                  state_in = lps_pkg::ST_MARK_CHK;
               end
            end
         end
         lps_pkg::ST_MARK_CHK: begin
            // unmarked candidate is prime; append while the list has room
            prime_in = !mark_rd_ff;
            if (!mark_rd_ff && (cnt_ff < CNT_W'(LIST_DEPTH))) begin
               list_we = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
            j_in     = '0;
            state_in = lps_pkg::ST_WALK_RD;
         end
         lps_pkg::ST_WALK_RD: begin
            if (j_ff < cnt_ff) begin
               state_in = lps_pkg::ST_WALK_MUL;
            end else begin
               walk_end = 1'b1;
            end
         end
         lps_pkg::ST_WALK_MUL: begin
            p_in     = list_rd_ff;
            prod_in  = PROD_W'(list_rd_ff) * PROD_W'(cand_ff);
            state_in = lps_pkg::ST_WALK_CHK;
         end
         lps_pkg::ST_WALK_CHK: begin
            if ((p_ff == '0) || (prod_ff > PROD_W'(limit_ff))) begin
               walk_end = 1'b1;
            end else begin
               if (prod_ff < PROD_W'(VALUE_RANGE)) begin
                  mark_we    = 1'b1;
                  mark_waddr = ADDR_W'(prod_ff);
                  mark_wdata = 1'b1;
                  if (ADDR_W'(prod_ff) > hi_ff) begin
                     hi_in = ADDR_W'(prod_ff);
                  end
               end
               div_start = 1'b1;
               state_in  = lps_pkg::ST_WALK_DIV;
            end
         end
         lps_pkg::ST_WALK_DIV: begin
            if (div_stat.done) begin
               if (div_stat.rem_zero) begin
                  walk_end = 1'b1;
               end else begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = lps_pkg::ST_WALK_RD;
               end
            end
         end
         lps_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load       = 1'b1;
               clr_pending_in = 1'b0;
               state_in       = clr_pending_ff ? lps_pkg::ST_CLEAR : lps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lps_pkg::ST_IDLE;
         end
      endcase

      // end of walk: stage the result and move the counter on
      if (walk_end) begin
         res_cand_in  = cand_ff;
         res_prime_in = prime_ff;
         res_found_in = FOUND_W'(cnt_ff);
         res_done_in  = 1'b0;
         next_cand_in = CAND_W'(cand_ff) + CAND_W'(1);
         state_in     = lps_pkg::ST_FINISH;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lps_pkg::ST_CLEAR;
         limit_ff       <= lps_pkg::LIMIT_RESET;
         next_cand_ff   <= lps_pkg::CAND_START;
         cnt_ff         <= '0;
         j_ff           <= '0;
         clr_ff         <= '0;
         hi_ff          <= ADDR_W'(VALUE_RANGE - 1);
         clr_pending_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_cand_ff   <= next_cand_in;
         cnt_ff         <= cnt_in;
         j_ff           <= j_in;
         clr_ff         <= clr_in;
         hi_ff          <= hi_in;
         clr_pending_ff <= clr_pending_in;
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      p_ff         <= p_in;
      prod_ff      <= prod_in;
      prime_ff     <= prime_in;
      res_cand_ff  <= res_cand_in;
      res_prime_ff <= res_prime_in;
      res_found_ff <= res_found_in;
      res_done_ff  <= res_done_in;
      if (rsp_load) begin
         rsp_cand_ff  <= res_cand_ff;
         rsp_prime_ff <= res_prime_ff;
         rsp_found_ff <= res_found_ff;
         rsp_done_ff  <= res_done_ff;
      end
   end

   // composite mark memory
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      mark_rd_ff <= mark_mem[mark_raddr];
   end

   // prime list memory
   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[cnt_ff[LIST_W-1:0]] <= cand_ff;
      end
      list_rd_ff <= list_mem[j_ff[LIST_W-1:0]];
   end

   // channel connections
   assign req_chan.ready           = req_ready;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.candidate_value = rsp_cand_ff;
   assign rsp_chan.is_prime        = rsp_prime_ff;
   assign rsp_chan.primes_found    = rsp_found_ff;
   assign rsp_chan.done_res        = rsp_done_ff;

`ifndef SYNTHESIS
   // list fill never exceeds its depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(LIST_DEPTH))
      else $error("prime count exceeds list depth");

   // a list append advances the count by one
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      list_we |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("list append did not advance count");

   // remainder results arrive only while the walk waits for them
   a_div_in_walk: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == lps_pkg::ST_WALK_DIV))
      else $error("remainder result outside walk");

   // a sweep never runs past the highest entry it has to clear
   a_clear_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lps_pkg::ST_CLEAR) |-> (clr_ff <= hi_ff))
      else $error("clear sweep beyond marked range");
`endif

endmodule

@@ hdl/lps_rem_unit.sv @@
// lps_rem_unit: bit-serial restoring remainder, one quotient bit per cycle.
// Depends on lps_pkg for the status struct; the divisor must be nonzero.
module lps_rem_unit #(
   parameter int DATA_W = lps_pkg::DATA_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DATA_W-1:0]       dividend,
   input  logic [DATA_W-1:0]       divisor,
   output lps_pkg::div_status_type status
);

   localparam int STEP_W = $clog2(DATA_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvd_ff, dvd_in;
   logic [DATA_W-1:0] dsr_ff, dsr_in;
   logic [DATA_W:0]   trial;

   // one shift-subtract step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, dvd_ff[DATA_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DATA_W);
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DATA_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = DATA_W'(trial);
         end
         dvd_in  = {dvd_ff[DATA_W-2:0], 1'b0};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule
